/* hdl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Widths and rounding helpers shared by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int COORD_W    = 32;   // Q16.16 coordinate
  localparam int UNIT_W     = 18;   // Q2.16 axis component
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = COORD_W + UNIT_W;   // coordinate times axis
  localparam int CROSS_W    = PROD_W + 1;
  localparam int DOT_W      = PROD_W + 2;
  localparam int TUP_W      = 2 * UNIT_W;         // axis times axis
  localparam int MAG_W      = 30;                 // scaled magnitude, top bit at 29
  localparam int LEN_W      = 2 * MAG_W + 2;      // sum of three squares
  localparam int ROOT_W     = LEN_W / 2;
  localparam int QB         = UNIT_W - 1;         // quotient bits
  localparam int NUM_W      = ROOT_W + FRAC_W;    // rounded dividend
  localparam int IN_DATA_W  = 9 * COORD_W;
  localparam int OUT_DATA_W = ((9 * UNIT_W + 3 * COORD_W + 7) / 8) * 8;
  localparam int PAD_W      = OUT_DATA_W - 9 * UNIT_W - 3 * COORD_W;
  localparam int UNIT_ONE   = 1 << FRAC_W;

  // drop 16 fraction bits, ties away from zero, clamp to +-1.0
  function automatic logic signed [UNIT_W-1:0] rnd_clamp_unit(
    input logic signed [TUP_W:0] v);
    logic [TUP_W:0]      mag;
    logic [TUP_W:0]      q;
    logic [UNIT_W-1:0]   qc;
    mag = v[TUP_W] ? (TUP_W+1)'(-v) : (TUP_W+1)'(v);
    q   = (mag + (TUP_W+1)'(1 << (FRAC_W - 1))) >> FRAC_W;
    qc  = (q > (TUP_W+1)'(UNIT_ONE)) ? UNIT_W'(UNIT_ONE) : q[UNIT_W-1:0];
    return v[TUP_W] ? -$signed(qc) : $signed(qc);
  endfunction

  // drop 16 fraction bits, ties away from zero, saturate to 32 bits
  function automatic logic signed [COORD_W-1:0] rnd_sat32(
    input logic signed [DOT_W:0] v);
    logic [DOT_W:0]              mag;
    logic [DOT_W:0]              q;
    logic signed [COORD_W-1:0]   r;
    mag = v[DOT_W] ? (DOT_W+1)'(-v) : (DOT_W+1)'(v);
    q   = (mag + (DOT_W+1)'(1 << (FRAC_W - 1))) >> FRAC_W;
    if (v[DOT_W]) begin
      if (q >= (DOT_W+1)'(64'h8000_0000)) r = {1'b1, {(COORD_W-1){1'b0}}};
      else r = -$signed(q[COORD_W-1:0]);
    end else begin
      if (q > (DOT_W+1)'(64'h7FFF_FFFF)) r = {1'b0, {(COORD_W-1){1'b1}}};
      else r = $signed(q[COORD_W-1:0]);
    end
    return r;
  endfunction

endpackage

/* hdl/look_at_view_matrix_unit.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Camera view transform from eye, target and up: three basis rows and shift.
// ----------------------------------------------------------------------------
// One item is taken per clock while s_tready is high, and each result appears
// on m_tdata after its transfer has passed stage A, the two normalizers, each
// with a square root and a divider that resolve one bit per stage (55 stages
// apiece), the cross and dot product stages, the pack stage and the output
// register. A two-entry output register absorbs backpressure; s_tready drops
// only while both entries hold results, and then the whole pipeline holds.
module look_at_view_matrix_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [lav_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
  // back_x, back_y, back_z, shift_x, shift_y, shift_z, zero pad
  output logic [lav_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import lav_pkg::*;

  logic en;
  logic skid_valid;
  logic out_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic [OUT_DATA_W-1:0] out_data;

  assign en       = ~skid_valid;
  assign s_tready = en;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // stage A: eye minus target
  logic                    va;
  logic [2:0][DIFF_W-1:0]  diff_a;
  logic [2:0][COORD_W-1:0] eye_a;
  logic [2:0][COORD_W-1:0] up_a;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        eye_a[l]  <= s_tdata[COORD_W*l +: COORD_W];
        up_a[l]   <= s_tdata[COORD_W*(6+l) +: COORD_W];
        diff_a[l] <= DIFF_W'($signed(s_tdata[COORD_W*l +: COORD_W]))
                   - DIFF_W'($signed(s_tdata[COORD_W*(3+l) +: COORD_W]));
      end
    end
  end

  // back axis
  logic                    vb;
  logic [2:0][UNIT_W-1:0]  back_b;
  logic [6*COORD_W-1:0]    side1;
  logic [2:0][COORD_W-1:0] eye_b;
  logic [2:0][COORD_W-1:0] up_b;

  lav_norm #(
    .IN_W   (DIFF_W),
    .SIDE_W (6 * COORD_W)
  ) u_norm_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va),
    .in_c      (diff_a),
    .in_side   ({up_a, eye_a}),
    .out_valid (vb),
    .out_n     (back_b),
    .out_side  (side1)
  );

  assign eye_b = side1[3*COORD_W-1:0];
  assign up_b  = side1[6*COORD_W-1:3*COORD_W];

  // stage C1: up cross back partial products
  logic                    vc1;
  logic signed [PROD_W-1:0] cp [6];
  logic [2:0][COORD_W-1:0] eye_c1;
  logic [2:0][UNIT_W-1:0]  back_c1;

  always_ff @(posedge clk) begin
    if (rst) vc1 <= 1'b0;
    else if (en) vc1 <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_c1  <= eye_b;
      back_c1 <= back_b;
      cp[0]   <= $signed(up_b[1]) * $signed(back_b[2]);
      cp[1]   <= $signed(up_b[2]) * $signed(back_b[1]);
      cp[2]   <= $signed(up_b[2]) * $signed(back_b[0]);
      cp[3]   <= $signed(up_b[0]) * $signed(back_b[2]);
      cp[4]   <= $signed(up_b[0]) * $signed(back_b[1]);
      cp[5]   <= $signed(up_b[1]) * $signed(back_b[0]);
    end
  end

  // stage C2: cross differences
  logic                    vc2;
  logic [2:0][CROSS_W-1:0] sc_c2;
  logic [2:0][COORD_W-1:0] eye_c2;
  logic [2:0][UNIT_W-1:0]  back_c2;

  always_ff @(posedge clk) begin
    if (rst) vc2 <= 1'b0;
    else if (en) vc2 <= vc1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_c2  <= eye_c1;
      back_c2 <= back_c1;
      for (int l = 0; l < 3; l++) begin
        sc_c2[l] <= CROSS_W'(cp[2*l]) - CROSS_W'(cp[2*l+1]);
      end
    end
  end

  // side axis
  logic                             vd;
  logic [2:0][UNIT_W-1:0]           side_d;
  logic [3*UNIT_W+3*COORD_W-1:0]    side2;
  logic [2:0][COORD_W-1:0]          eye_d;
  logic [2:0][UNIT_W-1:0]           back_d;

  lav_norm #(
    .IN_W   (CROSS_W),
    .SIDE_W (3 * UNIT_W + 3 * COORD_W)
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc2),
    .in_c      (sc_c2),
    .in_side   ({back_c2, eye_c2}),
    .out_valid (vd),
    .out_n     (side_d),
    .out_side  (side2)
  );

  assign eye_d  = side2[3*COORD_W-1:0];
  assign back_d = side2[3*UNIT_W+3*COORD_W-1:3*COORD_W];

  // stage T1: back cross side products and row dot eye products
  logic                     vt1;
  logic signed [TUP_W-1:0]  tp  [6];
  logic signed [PROD_W-1:0] dps [3];
  logic signed [PROD_W-1:0] dpb [3];
  logic [2:0][COORD_W-1:0]  eye_t1;
  logic [2:0][UNIT_W-1:0]   side_t1;
  logic [2:0][UNIT_W-1:0]   back_t1;

  always_ff @(posedge clk) begin
    if (rst) vt1 <= 1'b0;
    else if (en) vt1 <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_t1  <= eye_d;
      side_t1 <= side_d;
      back_t1 <= back_d;
      tp[0]   <= $signed(back_d[1]) * $signed(side_d[2]);
      tp[1]   <= $signed(back_d[2]) * $signed(side_d[1]);
      tp[2]   <= $signed(back_d[2]) * $signed(side_d[0]);
      tp[3]   <= $signed(back_d[0]) * $signed(side_d[2]);
      tp[4]   <= $signed(back_d[0]) * $signed(side_d[1]);
      tp[5]   <= $signed(back_d[1]) * $signed(side_d[0]);
      for (int l = 0; l < 3; l++) begin
        dps[l] <= $signed(side_d[l]) * $signed(eye_d[l]);
        dpb[l] <= $signed(back_d[l]) * $signed(eye_d[l]);
      end
    end
  end

  // stage T2: true up rounding, side and back dot sums
  logic                    vt2;
  logic [2:0][UNIT_W-1:0]  tu_t2;
  logic signed [DOT_W-1:0] sum_s_t2;
  logic signed [DOT_W-1:0] sum_b_t2;
  logic [2:0][COORD_W-1:0] eye_t2;
  logic [2:0][UNIT_W-1:0]  side_t2;
  logic [2:0][UNIT_W-1:0]  back_t2;

  always_ff @(posedge clk) begin
    if (rst) vt2 <= 1'b0;
    else if (en) vt2 <= vt1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_t2   <= eye_t1;
      side_t2  <= side_t1;
      back_t2  <= back_t1;
      for (int l = 0; l < 3; l++) begin
        tu_t2[l] <= rnd_clamp_unit((TUP_W+1)'(tp[2*l]) - (TUP_W+1)'(tp[2*l+1]));
      end
      sum_s_t2 <= DOT_W'(dps[0]) + DOT_W'(dps[1]) + DOT_W'(dps[2]);
      sum_b_t2 <= DOT_W'(dpb[0]) + DOT_W'(dpb[1]) + DOT_W'(dpb[2]);
    end
  end

  // stage T3: true up dot eye products
  logic                     vt3;
  logic signed [PROD_W-1:0] dpu [3];
  logic signed [DOT_W-1:0]  sum_s_t3;
  logic signed [DOT_W-1:0]  sum_b_t3;
  logic [2:0][UNIT_W-1:0]   tu_t3;
  logic [2:0][UNIT_W-1:0]   side_t3;
  logic [2:0][UNIT_W-1:0]   back_t3;

  always_ff @(posedge clk) begin
    if (rst) vt3 <= 1'b0;
    else if (en) vt3 <= vt2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s_t3 <= sum_s_t2;
      sum_b_t3 <= sum_b_t2;
      tu_t3    <= tu_t2;
      side_t3  <= side_t2;
      back_t3  <= back_t2;
      for (int l = 0; l < 3; l++) begin
        dpu[l] <= $signed(tu_t2[l]) * $signed(eye_t2[l]);
      end
    end
  end

  // stage T4: true up dot sum
  logic                    vt4;
  logic signed [DOT_W-1:0] sum_s_t4;
  logic signed [DOT_W-1:0] sum_u_t4;
  logic signed [DOT_W-1:0] sum_b_t4;
  logic [2:0][UNIT_W-1:0]  tu_t4;
  logic [2:0][UNIT_W-1:0]  side_t4;
  logic [2:0][UNIT_W-1:0]  back_t4;

  always_ff @(posedge clk) begin
    if (rst) vt4 <= 1'b0;
    else if (en) vt4 <= vt3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s_t4 <= sum_s_t3;
      sum_b_t4 <= sum_b_t3;
      sum_u_t4 <= DOT_W'(dpu[0]) + DOT_W'(dpu[1]) + DOT_W'(dpu[2]);
      tu_t4    <= tu_t3;
      side_t4  <= side_t3;
      back_t4  <= back_t3;
    end
  end

  // stage T5: negate, round and saturate the translation, pack the result
  logic                  pv;
  logic [OUT_DATA_W-1:0] pd;

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (en) pv <= vt4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd <= {{PAD_W{1'b0}},
             rnd_sat32(-((DOT_W+1)'(sum_b_t4))),
             rnd_sat32(-((DOT_W+1)'(sum_u_t4))),
             rnd_sat32(-((DOT_W+1)'(sum_s_t4))),
             back_t4, tu_t4, side_t4};
    end
  end

  // output register with one skid entry
  logic out_take;

  assign out_take = m_tready | ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pv & en;
      end
    end else if (pv & en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data <= skid_valid ? skid_data : pd;
    end else if (pv & en) begin
      skid_data <= pd;
    end
  end

endmodule

/* hdl/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale to a fixed exponent, sum of squares,
// bit-per-stage square root and bit-per-stage division to Q2.16.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0][IN_W-1:0]                 in_c,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output logic [2:0][lav_pkg::UNIT_W-1:0]      out_n,
  output logic [SIDE_W-1:0]                    out_side
);
  import lav_pkg::*;

  localparam int PW = $clog2(IN_W);
  localparam logic [PW-1:0] TOP_POS = PW'(MAG_W - 1);

  typedef struct packed {
    logic [2:0]        sgn;
    logic              zero;
    logic [SIDE_W-1:0] side;
  } tag_t;

  function automatic logic [PW-1:0] lead_pos(input logic [IN_W-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (x[b]) p = PW'(b);
    end
    return p;
  endfunction

  // stage 1: magnitudes and largest magnitude
  logic [2:0][IN_W-1:0] mag_c;
  logic [IN_W-1:0]      mx_c;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_c[l] = in_c[l][IN_W-1] ? (~in_c[l] + 1'b1) : in_c[l];
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  logic                 v1;
  tag_t                 t1;
  logic [2:0][IN_W-1:0] mag1;
  logic [IN_W-1:0]      mx1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1.sgn  <= {in_c[2][IN_W-1], in_c[1][IN_W-1], in_c[0][IN_W-1]};
      t1.zero <= (mx_c == '0);
      t1.side <= in_side;
      mag1    <= mag_c;
      mx1     <= mx_c;
    end
  end

  // stage 2: leading one of the largest magnitude
  logic                 v2;
  tag_t                 t2;
  logic [2:0][IN_W-1:0] mag2;
  logic [PW-1:0]        p2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2   <= t1;
      mag2 <= mag1;
      p2   <= lead_pos(mx1);
    end
  end

  // stage 3: shift so the largest magnitude has its top bit at 29
  logic [2:0][MAG_W-1:0] m_c;

  always_comb begin
    logic [IN_W+MAG_W-1:0] wide;
    for (int l = 0; l < 3; l++) begin
      wide = {{MAG_W{1'b0}}, mag2[l]};
      if (p2 >= TOP_POS) wide = wide >> (p2 - TOP_POS);
      else wide = wide << (TOP_POS - p2);
      m_c[l] = wide[MAG_W-1:0];
    end
  end

  logic                  v3;
  tag_t                  t3;
  logic [2:0][MAG_W-1:0] m3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3 <= t2;
      m3 <= m_c;
    end
  end

  // stage 4: squares
  logic                    v4;
  tag_t                    t4;
  logic [2:0][MAG_W-1:0]   m4;
  logic [2:0][2*MAG_W-1:0] sq4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4 <= t3;
      m4 <= m3;
      for (int l = 0; l < 3; l++) begin
        sq4[l] <= m3[l] * m3[l];
      end
    end
  end

  // square root, one result bit per stage; index 0 holds the sum of squares
  logic                  sv    [ROOT_W+1];
  tag_t                  st    [ROOT_W+1];
  logic [2:0][MAG_W-1:0] sm    [ROOT_W+1];
  logic [LEN_W-1:0]      srem  [ROOT_W+1];
  logic [ROOT_W-1:0]     sroot [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]    <= t4;
      sm[0]    <= m4;
      srem[0]  <= LEN_W'(sq4[0]) + LEN_W'(sq4[1]) + LEN_W'(sq4[2]);
      sroot[0] <= '0;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int BIT = ROOT_W - 1 - j;
    logic [LEN_W:0] trial;
    logic           take;

    // (root + 2^bit)^2 - root^2
    assign trial = ((LEN_W+1)'(sroot[j]) << (BIT + 1)) + ((LEN_W+1)'(1) << (2 * BIT));
    assign take  = {1'b0, srem[j]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (en) sv[j+1] <= sv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1]    <= st[j];
        sm[j+1]    <= sm[j];
        srem[j+1]  <= take ? LEN_W'({1'b0, srem[j]} - trial) : srem[j];
        sroot[j+1] <= take ? (sroot[j] | (ROOT_W'(1) << BIT)) : sroot[j];
      end
    end
  end

  // division, one quotient bit per stage; index 0 holds the rounded dividend
  logic                  dv    [QB+1];
  tag_t                  dt    [QB+1];
  logic [ROOT_W-1:0]     dr    [QB+1];
  logic [2:0][NUM_W-1:0] drem  [QB+1];
  logic [2:0][QB-1:0]    dq    [QB+1];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= sv[ROOT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt[0] <= st[ROOT_W];
      dr[0] <= sroot[ROOT_W];
      dq[0] <= '0;
      for (int l = 0; l < 3; l++) begin
        drem[0][l] <= (NUM_W'(sm[ROOT_W][l]) << FRAC_W) + NUM_W'(sroot[ROOT_W] >> 1);
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int BIT = QB - 1 - j;
    logic [NUM_W-1:0] dsh;

    assign dsh = NUM_W'(dr[j]) << BIT;

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dt[j+1] <= dt[j];
        dr[j+1] <= dr[j];
        for (int l = 0; l < 3; l++) begin
          if (drem[j][l] >= dsh) begin
            drem[j+1][l] <= drem[j][l] - dsh;
            dq[j+1][l]   <= dq[j][l] | (QB'(1) << BIT);
          end else begin
            drem[j+1][l] <= drem[j][l];
            dq[j+1][l]   <= dq[j][l];
          end
        end
      end
    end
  end

  // sign back on, zero vector gives zero axis
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= dt[QB].side;
      for (int l = 0; l < 3; l++) begin
        if (dt[QB].zero) out_n[l] <= '0;
        else if (dt[QB].sgn[l]) out_n[l] <= -{1'b0, dq[QB][l]};
        else out_n[l] <= {1'b0, dq[QB][l]};
      end
    end
  end

endmodule

/* hdl/lav_chk.sv */
// ----------------------------------------------------------------------------
// lav_chk
// Port-level checks for the look-at view matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module lav_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [lav_pkg::IN_DATA_W-1:0]    s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [lav_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // input side only blocks when a result is waiting
  a_block_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input blocked with no result pending");

  // input side only closes after an output stall
  a_block_after_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input blocked without output backpressure");

endmodule

bind look_at_view_matrix_unit lav_chk u_lav_chk (.*);

/* verif/look_at_view_matrix_checker.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_checker
// Watches both stream channels of the view matrix unit, computes the expected
// basis rows and shift for every input transfer and compares each output
// transfer field by field against the oldest pending view.
// ----------------------------------------------------------------------------
module look_at_view_matrix_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [lav_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [lav_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             fail_count,
  output int                             pending_views
);
  import lav_pkg::*;

  typedef struct {
    longint row[9];
    longint shift[3];
  } view_t;

  view_t pending_q[$];

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint root64(longint x);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // scale until the largest magnitude sits in [2^29, 2^30), then divide by root
  function automatic void unit_vec(input longint c[3], output longint n[3]);
    longint m[3];
    longint mx;
    longint r;
    longint q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) n[i] = 0;
      return;
    end
    while (mx >= (64'sd1 << 30)) begin
      mx = mx >>> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
    end
    while (mx < (64'sd1 << 29)) begin
      mx = mx <<< 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
    end
    r = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * UNIT_ONE + r / 2) / r;
      n[i] = (c[i] < 0) ? -q : q;
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint drop_frac(longint v);
    longint q;
    q = (abs64(v) + 32768) >>> 16;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic view_t camera_view(logic [IN_DATA_W-1:0] d);
    view_t v;
    longint eye[3], tgt[3], up[3], diff[3], back[3], sc[3], side[3], tu[3];
    longint dot;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[i*32 +: 32]));
      tgt[i] = longint'($signed(d[(3+i)*32 +: 32]));
      up[i]  = longint'($signed(d[(6+i)*32 +: 32]));
      diff[i] = eye[i] - tgt[i];
    end
    unit_vec(diff, back);
    cross3(up, back, sc);
    unit_vec(sc, side);
    cross3(back, side, tu);
    for (int i = 0; i < 3; i++) begin
      v.row[i]   = side[i];
      v.row[3+i] = clip(drop_frac(tu[i]), -UNIT_ONE, UNIT_ONE);
      v.row[6+i] = back[i];
    end
    for (int j = 0; j < 3; j++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot += v.row[j*3+i] * eye[i];
      v.shift[j] = clip(drop_frac(-dot), -64'sd2147483648, 64'sd2147483647);
    end
    return v;
  endfunction

  function automatic string field_name(int k);
    string axis[3] = '{"x", "y", "z"};
    string base[4] = '{"side_", "true_up_", "back_", "shift_"};
    return {base[k/3], axis[k%3]};
  endfunction

  always @(posedge clk) begin
    view_t  exp_v;
    longint got;
    int     errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) pending_q.push_back(camera_view(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          $error("output transfer with no view pending");
          errs++;
        end else begin
          exp_v = pending_q.pop_front();
          for (int k = 0; k < 12; k++) begin
            if (k < 9) got = longint'($signed(m_tdata[k*UNIT_W +: UNIT_W]));
            else got = longint'($signed(m_tdata[9*UNIT_W + (k-9)*32 +: 32]));
            if (got != ((k < 9) ? exp_v.row[k] : exp_v.shift[k-9])) begin
              $error("%s: expected %0d, got %0d", field_name(k),
                     (k < 9) ? exp_v.row[k] : exp_v.shift[k-9], got);
              errs++;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_views <= pending_q.size();
  end
endmodule

/* verif/tb_look_at_view_matrix_unit.sv */
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix_unit
// Drives camera triples into the view matrix unit with bursty input and a
// stalling output side; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix_unit;
  import lav_pkg::*;

  localparam int NUM_RANDOM = 1700;
  localparam int LATENCY    = 119;
  localparam int CYCLE_CAP  = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    fail_count;
  int                    pending_views;
  int                    cycle_count = 0;
  bit                    hold_off = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  look_at_view_matrix_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  look_at_view_matrix_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_views(pending_views)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: phases of always ready, occasional stalls and frequent stalls, plus one long hold-off
  initial begin
    int mode;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 1'b0;
      else begin
        mode = (cycle_count / 300) % 3;
        if (mode == 0) m_tready <= 1'b1;
        else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  function automatic logic [31:0] coord_pick();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 64)) - 32);
      4: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [IN_DATA_W-1:0] d);
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack9(int v[9]);
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < 9; i++) d[i*32 +: 32] = v[i];
    return d;
  endfunction

  initial begin
    logic [IN_DATA_W-1:0] d;
    int burst;
    int mn = 32'sh8000_0000;
    int mx = 32'sh7FFF_FFFF;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: standard camera, eye on target, up parallel, zero up, extremes
    send(pack9('{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0}));
    send(pack9('{3 << 16, 3 << 16, 3 << 16, 3 << 16, 3 << 16, 3 << 16, 0, 1 << 16, 0}));
    send(pack9('{0, 7 << 16, 0, 0, 0, 0, 0, 1 << 16, 0}));
    send(pack9('{1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 0, 0, 0}));
    send(pack9('{mx, mx, mx, mn, mn, mn, mn, mx, 0}));
    send(pack9('{mn, mn, mn, mx, mx, mx, mx, mn, mx}));
    send(pack9('{mx, mn, mx, mn, mx, mn, mn, mn, mn}));
    send(pack9('{mn, 0, 0, mx, 0, 0, 0, mx, 0}));
    send(pack9('{1, 0, 0, 0, 0, 0, 0, 0, 1}));
    send(pack9('{-1, -1, -1, 0, 0, 0, 1, -1, 0}));
    send(pack9('{mx, mx, mx, 0, 0, 0, mn, mn, mn}));
    send(pack9('{'1, '1, '1, '1, '1, '1, '1, '1, '1}));
    send(pack9('{1 << 16, 0, 0, -1 << 16, 0, 0, 0, 1 << 16, 1 << 16}));
    idle(1);

    // first pause: let everything drain
    while (pending_views != 0) @(posedge clk);

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      // long receiver hold-off once in the middle, input keeps offering
      if (n >= NUM_RANDOM / 2 && n < NUM_RANDOM / 2 + 40 && !hold_off) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
        for (int i = 0; i < 9; i++) d[i*32 +: 32] = coord_pick();
        // occasional eye on target or up equal to eye
        if ($urandom_range(0, 15) == 0) d[3*32 +: 96] = d[0 +: 96];
        if ($urandom_range(0, 15) == 0) d[6*32 +: 96] = d[0 +: 96];
        send(d);
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
    s_tvalid <= 1'b0;

    while (pending_views != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

/* filelist.f */
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/look_at_view_matrix_unit.sv
hdl/lav_chk.sv
verif/look_at_view_matrix_checker.sv
verif/tb_look_at_view_matrix_unit.sv
